### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// property checked on every edge, reset included
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

### sv/etfr_pkg.sv
`timescale 1ns / 1ps

package etfr_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HEAD_BYTE     = 3'd0;
    localparam t_cfg_idx CFG_ESCAPE_BYTE   = 3'd1;
    localparam t_cfg_idx CFG_ESCAPE_TAIL_A = 3'd2;
    localparam t_cfg_idx CFG_ESCAPE_TAIL_B = 3'd3;
    localparam t_cfg_idx CFG_REMOTE_TYPE   = 3'd4;
    localparam t_cfg_idx CFG_LOCAL_TYPE    = 3'd5;
    localparam t_cfg_idx CFG_MIN_LENGTH    = 3'd6;
    localparam t_cfg_idx CFG_MAX_LENGTH    = 3'd7;

    localparam logic [7:0] RST_HEAD_BYTE     = 8'd126;
    localparam logic [7:0] RST_ESCAPE_BYTE   = 8'd125;
    localparam logic [7:0] RST_ESCAPE_TAIL_A = 8'd94;
    localparam logic [7:0] RST_ESCAPE_TAIL_B = 8'd93;
    localparam logic [7:0] RST_REMOTE_TYPE   = 8'd1;
    localparam logic [7:0] RST_LOCAL_TYPE    = 8'd2;
    localparam logic [7:0] RST_MIN_LENGTH    = 8'd1;
    localparam logic [7:0] RST_MAX_LENGTH    = 8'd64;

    localparam logic [7:0] ESC_OFFSET = 8'h20;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ABORT   = 1'b1;

    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] escape_byte;
        logic [7:0] escape_tail_a;
        logic [7:0] escape_tail_b;
        logic [7:0] remote_type;
        logic [7:0] local_type;
        logic [7:0] min_length;
        logic [7:0] max_length;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic       last;
        logic       frame_is_local;
        logic [7:0] frame_length;
    } t_result;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_ESCAPE = 3'd4
    } t_phase;

endpackage

### sv/escaped_typed_frame_receiver.sv
// path: an accepted byte waits in the input register; its result is registered in the output register
// throughput: one received byte per cycle while the result side does not stall, set by the one-pass phase update
// stalls on the result side hold the input register and then the input ready
// reset: synchronous active low; clears phase, counters and valids and loads the
// register defaults
`timescale 1ns / 1ps

module escaped_typed_frame_receiver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  etfr_pkg::t_cfg_idx i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [7:0]         o_payload_byte,
    output logic [7:0]         o_byte_index,
    output logic               o_last,
    output logic               o_frame_is_local,
    output logic [7:0]         o_frame_length
);
    import etfr_pkg::*;

    t_cfg       w_cfg;
    logic       w_fire;
    logic [7:0] w_byte;
    logic       w_free;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    etfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    etfr_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_down_free (w_free),
        .o_fire      (w_fire),
        .o_byte      (w_byte)
    );

    etfr_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fire      (w_fire),
        .i_byte      (w_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    etfr_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_payload_byte   = w_out.payload_byte;
    assign o_byte_index     = w_out.byte_index;
    assign o_last           = w_out.last;
    assign o_frame_is_local = w_out.frame_is_local;
    assign o_frame_length   = w_out.frame_length;

endmodule

### sv/etfr_cfg_regs.sv
`timescale 1ns / 1ps

module etfr_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  etfr_pkg::t_cfg_idx i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    output etfr_pkg::t_cfg    o_cfg
);
    import etfr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAD_BYTE:     n_cfg.head_byte     = i_cfg_data;
                CFG_ESCAPE_BYTE:   n_cfg.escape_byte   = i_cfg_data;
                CFG_ESCAPE_TAIL_A: n_cfg.escape_tail_a = i_cfg_data;
                CFG_ESCAPE_TAIL_B: n_cfg.escape_tail_b = i_cfg_data;
                CFG_REMOTE_TYPE:   n_cfg.remote_type   = i_cfg_data;
                CFG_LOCAL_TYPE:    n_cfg.local_type    = i_cfg_data;
                CFG_MIN_LENGTH:    n_cfg.min_length    = i_cfg_data;
                CFG_MAX_LENGTH:    n_cfg.max_length    = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte     <= RST_HEAD_BYTE;
            r_cfg.escape_byte   <= RST_ESCAPE_BYTE;
            r_cfg.escape_tail_a <= RST_ESCAPE_TAIL_A;
            r_cfg.escape_tail_b <= RST_ESCAPE_TAIL_B;
            r_cfg.remote_type   <= RST_REMOTE_TYPE;
            r_cfg.local_type    <= RST_LOCAL_TYPE;
            r_cfg.min_length    <= RST_MIN_LENGTH;
            r_cfg.max_length    <= RST_MAX_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/etfr_in_stage.sv
`timescale 1ns / 1ps

module etfr_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_down_free,
    output logic       o_fire,
    output logic [7:0] o_byte
);
    import etfr_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic       w_take;

    assign o_fire     = r_valid && i_down_free;
    assign o_rx_ready = !r_valid || o_fire;
    assign w_take     = i_rx_valid && o_rx_ready;
    assign n_valid    = w_take ? 1'b1 : (o_fire ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

### sv/etfr_deframe.sv
`timescale 1ns / 1ps

module etfr_deframe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etfr_pkg::t_cfg    i_cfg,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output etfr_pkg::t_result o_res
);
    import etfr_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_local;
    logic       n_local;
    logic [7:0] r_exp_len;
    logic [7:0] n_exp_len;
    logic [7:0] r_count;
    logic [7:0] n_count;

    logic       w_is_head;
    logic       w_head_hit;
    logic       w_is_local;
    logic       w_type_ok;
    logic       w_len_bad;
    logic       w_is_esc;
    logic       w_tail_ok;
    logic [7:0] w_count_inc;
    logic       w_done;
    logic [7:0] w_unesc;

    assign w_is_head   = (i_byte == i_cfg.head_byte);
    assign w_head_hit  = w_is_head && (r_phase != PH_IDLE);
    assign w_is_local  = (i_byte == i_cfg.local_type);
    assign w_type_ok   = w_is_local || (i_byte == i_cfg.remote_type);
    assign w_len_bad   = (i_byte > i_cfg.max_length) || (i_byte < i_cfg.min_length);
    assign w_is_esc    = (i_byte == i_cfg.escape_byte);
    assign w_tail_ok   = (i_byte == i_cfg.escape_tail_a) || (i_byte == i_cfg.escape_tail_b);
    assign w_count_inc = r_count + 8'd1;
    assign w_done      = (w_count_inc == r_exp_len);
    assign w_unesc     = i_byte + ESC_OFFSET;

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_local   = r_local;
        n_exp_len = r_exp_len;
        n_count   = r_count;
        if (w_head_hit) begin
            n_phase = PH_TYPE;
            n_count = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (w_is_head) begin
                        n_phase = PH_TYPE;
                        n_count = '0;
                    end
                end
                PH_TYPE: begin
                    if (w_type_ok) begin
                        n_local = w_is_local;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end
                end
                PH_LENGTH: begin
                    if (w_len_bad) begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end else begin
                        n_exp_len = i_byte;
                        n_phase   = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (w_is_esc) begin
                        n_phase = PH_ESCAPE;
                    end else begin
                        n_count = w_count_inc;
                        n_phase = w_done ? PH_IDLE : PH_DATA;
                    end
                end
                PH_ESCAPE: begin
                    if (!w_tail_ok) begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end else begin
                        n_count = w_count_inc;
                        n_phase = w_done ? PH_IDLE : PH_DATA;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid        = 1'b0;
        o_res              = '0;
        o_res.kind         = KIND_PAYLOAD;
        if (w_head_hit) begin
            if (r_phase != PH_TYPE) begin
                o_res_valid = i_fire;
                o_res.kind  = KIND_ABORT;
            end
        end else begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (w_len_bad) begin
                        o_res_valid = i_fire;
                        o_res.kind  = KIND_ABORT;
                    end
                end
                PH_DATA: begin
                    if (!w_is_esc) begin
                        o_res_valid          = i_fire;
                        o_res.payload_byte   = i_byte;
                        o_res.byte_index     = r_count;
                        o_res.last           = w_done;
                        o_res.frame_is_local = r_local;
                        o_res.frame_length   = r_exp_len;
                    end
                end
                PH_ESCAPE: begin
                    o_res_valid = i_fire;
                    if (w_tail_ok) begin
                        o_res.payload_byte   = w_unesc;
                        o_res.byte_index     = r_count;
                        o_res.last           = w_done;
                        o_res.frame_is_local = r_local;
                        o_res.frame_length   = r_exp_len;
                    end else begin
                        o_res.kind = KIND_ABORT;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_local   <= 1'b0;
            r_exp_len <= '0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_local   <= n_local;
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
        end
    end

endmodule

### sv/etfr_out_reg.sv
`timescale 1ns / 1ps

module etfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_res_valid,
    input  etfr_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output etfr_pkg::t_result o_res
);
    import etfr_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_out_ready;
    assign n_valid = i_load ? i_res_valid : (i_out_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

### sv/etfr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module etfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_kind,
    input logic [7:0]         o_payload_byte,
    input logic [7:0]         o_byte_index,
    input logic               o_last,
    input logic               o_frame_is_local,
    input logic [7:0]         o_frame_length
);
    import etfr_pkg::*;

    logic        w_res_abort;
    logic        w_abort_zero;
    logic        w_res_last;
    logic        w_last_at_end;
    logic        w_stall;
    logic [26:0] w_res_bits;

    assign w_res_abort   = o_out_valid && (o_kind == KIND_ABORT);
    assign w_abort_zero  = (o_payload_byte == 8'd0) && (o_byte_index == 8'd0) && !o_last &&
                           !o_frame_is_local && (o_frame_length == 8'd0);
    assign w_res_last    = o_out_valid && (o_kind == KIND_PAYLOAD) && o_last;
    assign w_last_at_end = (8'(o_byte_index + 8'd1) == o_frame_length);
    assign w_stall       = o_out_valid && !i_out_ready;
    assign w_res_bits    = {o_kind, o_payload_byte, o_byte_index, o_last, o_frame_is_local,
                            o_frame_length};

    // an abort carries nothing but its kind
    `ASSERT_CLK_RST(a_abort_clean, i_clk, i_rst_n, w_res_abort |-> w_abort_zero)
    // the last byte of a frame sits at the declared length minus one
    `ASSERT_CLK_RST(a_last_index, i_clk, i_rst_n, w_res_last |-> w_last_at_end)
    // a stalled result holds its fields
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, w_stall |=> (o_out_valid && $stable(w_res_bits)))
    // nothing is offered right after reset
    `ASSERT_CLK(a_rst_empty, i_clk, (!$past(i_rst_n)) |-> !o_out_valid)

endmodule

bind escaped_typed_frame_receiver etfr_checker u_etfr_checker (.*);
